// File: sv/lsce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_pkg
// Shared constants for the lattice sphere cell extent unit.
// ----------------------------------------------------------------------------
package lsce_pkg;

    localparam int COORD_BITS   = 16;
    localparam int RADIUS_BITS  = 16;
    localparam int CELL_BITS    = 16;
    localparam int DIMS         = 3;

    localparam logic [CELL_BITS-1:0] CELL_MAX     = '1;
    localparam logic [CELL_BITS-1:0] EXTRA_SHELLS = CELL_BITS'(2);
    // largest floor term that still fits after the extra shells are added
    localparam logic [CELL_BITS-1:0] FLOOR_MAX    = CELL_MAX - EXTRA_SHELLS;

endpackage

// File: sv/lsce_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_in_if
// Lattice beat: sphere radius and three lattice vectors.
// ----------------------------------------------------------------------------
interface lsce_in_if #(
    parameter int COORD_BITS = lsce_pkg::COORD_BITS
);
    logic                                   valid;
    logic                                   ready;
    logic        [lsce_pkg::RADIUS_BITS-1:0] radius;
    logic signed [COORD_BITS-1:0]           v0_x;
    logic signed [COORD_BITS-1:0]           v0_y;
    logic signed [COORD_BITS-1:0]           v0_z;
    logic signed [COORD_BITS-1:0]           v1_x;
    logic signed [COORD_BITS-1:0]           v1_y;
    logic signed [COORD_BITS-1:0]           v1_z;
    logic signed [COORD_BITS-1:0]           v2_x;
    logic signed [COORD_BITS-1:0]           v2_y;
    logic signed [COORD_BITS-1:0]           v2_z;

    modport source (
        output valid, radius, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        input  ready
    );
    modport sink (
        input  valid, radius, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        output ready
    );
endinterface

// File: sv/lsce_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_out_if
// Extent beat: cell counts along each lattice direction and singular flag.
// ----------------------------------------------------------------------------
interface lsce_out_if;
    logic                             valid;
    logic                             ready;
    logic [lsce_pkg::CELL_BITS-1:0]   cells_along_0;
    logic [lsce_pkg::CELL_BITS-1:0]   cells_along_1;
    logic [lsce_pkg::CELL_BITS-1:0]   cells_along_2;
    logic                             singular;

    modport source (
        output valid, cells_along_0, cells_along_1, cells_along_2, singular,
        input  ready
    );
    modport sink (
        input  valid, cells_along_0, cells_along_1, cells_along_2, singular,
        output ready
    );
endinterface

// File: sv/lsce_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_geom
// Seven-stage front end: cross products, determinant, |cross|^2 and
// radius^2 * |cross|^2 for each direction.
// ----------------------------------------------------------------------------
module lsce_geom #(
    parameter int CB   = lsce_pkg::COORD_BITS,
    parameter int DETW = 3 * CB + 3,
    parameter int RHSW = 4 * CB + 4 + 2 * lsce_pkg::RADIUS_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [lsce_pkg::RADIUS_BITS-1:0]    radius,
    input  logic signed [CB-1:0]                vec [lsce_pkg::DIMS][lsce_pkg::DIMS],
    output logic                                out_valid,
    output logic [RHSW-1:0]                     rhs [lsce_pkg::DIMS],
    output logic [DETW-1:0]                     absdet,
    output logic                                singular
);
    localparam int N     = lsce_pkg::DIMS;
    localparam int PW    = 2 * CB;
    localparam int CRW   = 2 * CB + 1;
    localparam int DPW   = 3 * CB + 1;
    localparam int MW    = 2 * CB + 1;
    localparam int SQW   = 2 * MW;
    localparam int C2W   = SQW + 2;
    localparam int RSQW  = 2 * lsce_pkg::RADIUS_BITS;
    localparam int LO    = C2W / 2;
    localparam int HI    = C2W - LO;
    localparam int STG   = 7;

    logic [STG-1:0] vld_reg;

    // stage A
    logic signed [PW-1:0] pa_reg [N][N];
    logic signed [PW-1:0] pb_reg [N][N];
    logic signed [CB-1:0] v0a_reg [N];
    logic [lsce_pkg::RADIUS_BITS-1:0] rada_reg;
    // stage B
    logic signed [CRW-1:0] cr_reg [N][N];
    logic signed [CB-1:0]  v0b_reg [N];
    logic [lsce_pkg::RADIUS_BITS-1:0] radb_reg;
    // stage C
    logic signed [DPW-1:0] dp_reg [N];
    logic [MW-1:0]         mag_reg [N][N];
    logic [RSQW-1:0]       rsqc_reg;
    // stage D
    logic signed [DETW-1:0] det_reg;
    logic [SQW-1:0]         sq_reg [N][N];
    logic [RSQW-1:0]        rsqd_reg;
    // stage E
    logic [DETW-1:0] absde_reg;
    logic            singe_reg;
    logic [C2W-1:0]  c2_reg [N];
    logic [RSQW-1:0] rsqe_reg;
    // stage F
    logic [RSQW+LO-1:0] plo_reg [N];
    logic [RSQW+HI-1:0] phi_reg [N];
    logic [DETW-1:0]    absdf_reg;
    logic               singf_reg;
    // stage G
    logic [RHSW-1:0] rhs_reg [N];
    logic [DETW-1:0] absdg_reg;
    logic            singg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                // cross_i = v_j x v_m with (i, j, m) cyclic
                pa_reg[i][0] <= PW'(vec[(i+1)%N][1] * vec[(i+2)%N][2]);
                pb_reg[i][0] <= PW'(vec[(i+1)%N][2] * vec[(i+2)%N][1]);
                pa_reg[i][1] <= PW'(vec[(i+1)%N][2] * vec[(i+2)%N][0]);
                pb_reg[i][1] <= PW'(vec[(i+1)%N][0] * vec[(i+2)%N][2]);
                pa_reg[i][2] <= PW'(vec[(i+1)%N][0] * vec[(i+2)%N][1]);
                pb_reg[i][2] <= PW'(vec[(i+1)%N][1] * vec[(i+2)%N][0]);
                v0a_reg[i]   <= vec[0][i];
            end
            rada_reg <= radius;

            for (int i = 0; i < N; i++)
            begin
                for (int k = 0; k < N; k++)
                begin
                    cr_reg[i][k] <= CRW'(pa_reg[i][k]) - CRW'(pb_reg[i][k]);
                end
                v0b_reg[i] <= v0a_reg[i];
            end
            radb_reg <= rada_reg;

            for (int i = 0; i < N; i++)
            begin
                dp_reg[i] <= DPW'(v0b_reg[i] * cr_reg[0][i]);
                for (int k = 0; k < N; k++)
                begin
                    mag_reg[i][k] <= cr_reg[i][k][CRW-1] ? MW'(-cr_reg[i][k])
                                                         : MW'(cr_reg[i][k]);
                end
            end
            rsqc_reg <= RSQW'(radb_reg) * RSQW'(radb_reg);

            det_reg <= DETW'(dp_reg[0]) + DETW'(dp_reg[1]) + DETW'(dp_reg[2]);
            for (int i = 0; i < N; i++)
            begin
                for (int k = 0; k < N; k++)
                begin
                    sq_reg[i][k] <= SQW'(mag_reg[i][k]) * SQW'(mag_reg[i][k]);
                end
            end
            rsqd_reg <= rsqc_reg;

            absde_reg <= det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
            singe_reg <= (det_reg == '0);
            for (int i = 0; i < N; i++)
            begin
                c2_reg[i] <= C2W'(sq_reg[i][0]) + C2W'(sq_reg[i][1]) + C2W'(sq_reg[i][2]);
            end
            rsqe_reg <= rsqd_reg;

            // wide product split in two halves
            for (int i = 0; i < N; i++)
            begin
                plo_reg[i] <= (RSQW+LO)'(rsqe_reg) * (RSQW+LO)'(c2_reg[i][LO-1:0]);
                phi_reg[i] <= (RSQW+HI)'(rsqe_reg) * (RSQW+HI)'(c2_reg[i][C2W-1:LO]);
            end
            absdf_reg <= absde_reg;
            singf_reg <= singe_reg;

            for (int i = 0; i < N; i++)
            begin
                rhs_reg[i] <= RHSW'(plo_reg[i]) + (RHSW'(phi_reg[i]) << LO);
            end
            absdg_reg <= absdf_reg;
            singg_reg <= singf_reg;
        end
    end

    assign out_valid = vld_reg[STG-1];
    assign rhs       = rhs_reg;
    assign absdet    = absdg_reg;
    assign singular  = singg_reg;

endmodule

// File: sv/lsce_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lsce_isqrt #(
    parameter int XW  = 100,
    parameter int SBW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [XW-1:0]     x,
    input  logic [SBW-1:0]    side_in,
    output logic              out_valid,
    output logic [XW/2-1:0]   root,
    output logic [SBW-1:0]    side_out
);
    localparam int N  = XW / 2;
    localparam int RW = N + 2;

    logic [N-1:0]   vld_reg;
    logic [RW-1:0]  rem_reg  [N];
    logic [N-1:0]   root_reg [N];
    logic [XW-1:0]  x_reg    [N];
    logic [SBW-1:0] sb_reg   [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [RW-1:0]   rem_in;
        logic [N-1:0]    root_in;
        logic [XW-1:0]   x_in;
        logic [SBW-1:0]  sb_in;
        logic [RW+1:0]   cand;
        logic [RW+1:0]   trial;
        logic            ge;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x;
            assign sb_in   = side_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign sb_in   = sb_reg[s-1];
        end

        // bring down two radicand bits, try root*4+1
        assign cand  = {rem_in, x_in[XW-1 -: 2]};
        assign trial = (RW+2)'({root_in, 2'b01});
        assign ge    = (cand >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= RW'(ge ? cand - trial : cand);
                root_reg[s] <= {root_in[N-2:0], ge};
                x_reg[s]    <= x_in << 2;
                sb_reg[s]   <= sb_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = sb_reg[N-1];

endmodule

// File: sv/lsce_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsce_div
// Pipelined restoring divider with a CELL_BITS-bit quotient and an
// overflow flag raised when the quotient does not fit.
// ----------------------------------------------------------------------------
module lsce_div #(
    parameter int SW  = 50,
    parameter int DW  = 51,
    parameter int SBW = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [SW-1:0]                   num,
    input  logic [DW-1:0]                   den,
    input  logic [SBW-1:0]                  side_in,
    output logic                            out_valid,
    output logic [lsce_pkg::CELL_BITS-1:0]  quo,
    output logic                            ovf,
    output logic [SBW-1:0]                  side_out
);
    localparam int QB  = lsce_pkg::CELL_BITS;
    localparam int STG = QB + 1;
    localparam int CW  = (SW > DW) ? SW : DW;

    logic [STG-1:0] vld_reg;
    logic [DW-1:0]  rem_reg [STG];
    logic [QB-1:0]  low_reg [STG];
    logic [QB-1:0]  q_reg   [STG];
    logic [DW-1:0]  den_reg [STG];
    logic           ovf_reg [STG];
    logic [SBW-1:0] sb_reg  [STG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STG-2:0], in_valid};
        end
    end

    // head: quotient overflows when num >= den * 2^QB or den is zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= (CW'(num >> QB) >= CW'(den)) || (den == '0);
            rem_reg[0] <= DW'(num >> QB);
            low_reg[0] <= num[QB-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            sb_reg[0]  <= side_in;
        end
    end

    for (genvar s = 1; s < STG; s++)
    begin : g_stage
        logic [DW:0] cand;
        logic        ge;

        assign cand = {rem_reg[s-1], low_reg[s-1][QB-1]};
        assign ge   = (cand >= (DW+1)'(den_reg[s-1]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= DW'(ge ? cand - (DW+1)'(den_reg[s-1]) : cand);
                low_reg[s] <= low_reg[s-1] << 1;
                q_reg[s]   <= {q_reg[s-1][QB-2:0], ge};
                den_reg[s] <= den_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                sb_reg[s]  <= sb_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[STG-1];
    assign quo       = q_reg[STG-1];
    assign ovf       = ovf_reg[STG-1];
    assign side_out  = sb_reg[STG-1];

endmodule

// File: sv/lattice_sphere_cell_extent_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_sphere_cell_extent_unit
// Cells needed along each lattice vector to cover a sphere:
// floor(isqrt(r^2 * |v_j x v_k|^2) / |det|) + 2, saturating at 65535.
// ----------------------------------------------------------------------------
//  channel    | dir | payload
//  -----------+-----+--------------------------------------------------
//  lattice    | in  | radius, v0_x..v2_z          (valid/ready)
//  extent     | out | cells_along_0..2, singular  (valid/ready)
//
//  One beat per cycle while extent does not stall. The path runs through the
//  geometry stages, one square root bit per stage, the overflow head plus
//  one quotient bit per stage, and the output register.
//  Reset clears only the valid bits; no clearing pass.
//  A stall on extent freezes the whole pipeline in place; lattice.ready
//  is high whenever the output register is empty or being taken.
// ----------------------------------------------------------------------------
module lattice_sphere_cell_extent_unit #(
    parameter int COORD_BITS = lsce_pkg::COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    lsce_in_if.sink       lattice,
    lsce_out_if.source    extent
);
    localparam int N    = lsce_pkg::DIMS;
    localparam int CB   = COORD_BITS;
    localparam int DETW = 3 * CB + 3;
    localparam int RHSW = 4 * CB + 4 + 2 * lsce_pkg::RADIUS_BITS;
    localparam int SRW  = RHSW / 2;
    localparam int SBW  = DETW + 1;
    localparam int QB   = lsce_pkg::CELL_BITS;

    logic                  en;
    logic signed [CB-1:0]  vec [N][N];

    logic                  geo_valid;
    logic [RHSW-1:0]       geo_rhs [N];
    logic [DETW-1:0]       geo_absdet;
    logic                  geo_sing;

    logic                  sq_valid [N];
    logic [SRW-1:0]        sq_root  [N];
    logic [SBW-1:0]        sq_side  [N];

    logic                  dv_valid [N];
    logic [QB-1:0]         dv_quo   [N];
    logic                  dv_ovf   [N];
    logic                  dv_sing  [N];

    logic                  out_valid_reg;
    logic [QB-1:0]         cells_reg [N];
    logic                  sing_reg;
    logic [QB-1:0]         cells_next [N];

    assign en            = !out_valid_reg || extent.ready;
    assign lattice.ready = en;

    assign vec[0][0] = lattice.v0_x;
    assign vec[0][1] = lattice.v0_y;
    assign vec[0][2] = lattice.v0_z;
    assign vec[1][0] = lattice.v1_x;
    assign vec[1][1] = lattice.v1_y;
    assign vec[1][2] = lattice.v1_z;
    assign vec[2][0] = lattice.v2_x;
    assign vec[2][1] = lattice.v2_y;
    assign vec[2][2] = lattice.v2_z;

    lsce_geom #(
        .CB   (CB),
        .DETW (DETW),
        .RHSW (RHSW)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lattice.valid),
        .radius    (lattice.radius),
        .vec       (vec),
        .out_valid (geo_valid),
        .rhs       (geo_rhs),
        .absdet    (geo_absdet),
        .singular  (geo_sing)
    );

    for (genvar i = 0; i < N; i++)
    begin : g_lane
        lsce_isqrt #(
            .XW  (RHSW),
            .SBW (SBW)
        ) u_isqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (geo_valid),
            .x         (geo_rhs[i]),
            .side_in   ({geo_sing, geo_absdet}),
            .out_valid (sq_valid[i]),
            .root      (sq_root[i]),
            .side_out  (sq_side[i])
        );

        lsce_div #(
            .SW  (SRW),
            .DW  (DETW),
            .SBW (1)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .num       (sq_root[i]),
            .den       (sq_side[i][DETW-1:0]),
            .side_in   (sq_side[i][DETW]),
            .out_valid (dv_valid[i]),
            .quo       (dv_quo[i]),
            .ovf       (dv_ovf[i]),
            .side_out  (dv_sing[i])
        );

        always_comb
        begin
            if (dv_sing[i])
            begin
                cells_next[i] = lsce_pkg::CELL_MAX;
            end
            else if (dv_ovf[i] || (dv_quo[i] > lsce_pkg::FLOOR_MAX))
            begin
                cells_next[i] = lsce_pkg::CELL_MAX;
            end
            else
            begin
                cells_next[i] = dv_quo[i] + lsce_pkg::EXTRA_SHELLS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                cells_reg[i] <= cells_next[i];
            end
            sing_reg <= dv_sing[0];
        end
    end

    assign extent.valid         = out_valid_reg;
    assign extent.cells_along_0 = cells_reg[0];
    assign extent.cells_along_1 = cells_reg[1];
    assign extent.cells_along_2 = cells_reg[2];
    assign extent.singular      = sing_reg;

endmodule
